// ----- design/triangle_unit_normal_defines.svh -----
// assertion helpers for the triangle normal pipeline, used by tun_root
`ifndef TRIANGLE_UNIT_NORMAL_DEFINES_SVH
`define TRIANGLE_UNIT_NORMAL_DEFINES_SVH

// same-cycle implication
`define TUN_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TUN_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/tun_pkg.sv -----
`timescale 1ns / 1ps
package tun_pkg;
    localparam int NUM_AXES = 3;
    localparam int NORM_W   = 16;

    typedef enum logic [1:0] {
        AX_X = 2'd0,
        AX_Y = 2'd1,
        AX_Z = 2'd2
    } t_axis;
endpackage

// ----- design/tun_cross.sv -----
`timescale 1ns / 1ps
module tun_cross #(
    parameter int CW = 24
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic signed [CW-1:0] i_p1 [tun_pkg::NUM_AXES],
    input  logic signed [CW-1:0] i_p2 [tun_pkg::NUM_AXES],
    input  logic signed [CW-1:0] i_p3 [tun_pkg::NUM_AXES],
    output logic                o_valid,
    input  logic                i_ready,
    output logic signed [2*CW+1:0] o_c [tun_pkg::NUM_AXES]
);
    import tun_pkg::*;

    localparam int NS  = 3;
    localparam int DW  = CW + 1;
    localparam int CCW = 2 * CW + 2;

    logic [NS-1:0] r_vld;
    logic [NS-1:0] en;

    logic signed [DW-1:0]  r_a  [NUM_AXES];
    logic signed [DW-1:0]  r_b  [NUM_AXES];
    logic signed [CCW-1:0] r_pa [NUM_AXES];
    logic signed [CCW-1:0] r_pb [NUM_AXES];
    logic signed [CCW-1:0] r_c  [NUM_AXES];

    always_comb begin
        en[NS-1] = !r_vld[NS-1] || i_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (en[k]) begin
                    r_vld[k] <= (k == 0) ? i_valid : r_vld[(k == 0) ? 0 : k - 1];
                end
            end
        end
    end

    // edge vectors, products, cross
    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                r_a[i] <= DW'(i_p1[i]) - DW'(i_p2[i]);
                r_b[i] <= DW'(i_p1[i]) - DW'(i_p3[i]);
            end
        end
        if (en[1]) begin
            r_pa[AX_X] <= CCW'(r_a[AX_Y]) * CCW'(r_b[AX_Z]);
            r_pb[AX_X] <= CCW'(r_b[AX_Y]) * CCW'(r_a[AX_Z]);
            r_pa[AX_Y] <= CCW'(r_b[AX_X]) * CCW'(r_a[AX_Z]);
            r_pb[AX_Y] <= CCW'(r_a[AX_X]) * CCW'(r_b[AX_Z]);
            r_pa[AX_Z] <= CCW'(r_a[AX_X]) * CCW'(r_b[AX_Y]);
            r_pb[AX_Z] <= CCW'(r_b[AX_X]) * CCW'(r_a[AX_Y]);
        end
        if (en[2]) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                r_c[i] <= r_pa[i] - r_pb[i];
            end
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_vld[NS-1];
    assign o_c     = r_c;
endmodule

// ----- design/tun_square.sv -----
`timescale 1ns / 1ps
module tun_square #(
    parameter int CW = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [2*CW+1:0]        i_c [tun_pkg::NUM_AXES],
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [tun_pkg::NUM_AXES-1:0]  o_neg,
    output logic [4*CW+3:0]               o_sq [tun_pkg::NUM_AXES],
    output logic [4*CW+5:0]               o_sum,
    output logic                          o_zero
);
    import tun_pkg::*;

    localparam int NS = 4;
    localparam int MW = 2 * CW + 2;
    localparam int LW = MW / 2;
    localparam int HW = MW - LW;
    localparam int PW = 2 * HW;
    localparam int QW = 2 * MW;
    localparam int SW = QW + 2;

    logic [NS-1:0] r_vld;
    logic [NS-1:0] en;

    logic [NUM_AXES-1:0] r_neg0, r_neg1, r_neg2, r_neg3;
    logic [MW-1:0] r_mag [NUM_AXES];
    logic [PW-1:0] r_hh  [NUM_AXES];
    logic [PW-1:0] r_hl  [NUM_AXES];
    logic [PW-1:0] r_ll  [NUM_AXES];
    logic [QW-1:0] r_sq2 [NUM_AXES];
    logic [QW-1:0] r_sq3 [NUM_AXES];
    logic [SW-1:0] r_sum;
    logic          r_zero;

    always_comb begin
        en[NS-1] = !r_vld[NS-1] || i_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (en[k]) begin
                    r_vld[k] <= (k == 0) ? i_valid : r_vld[(k == 0) ? 0 : k - 1];
                end
            end
        end
    end

    // magnitude, split partial products, square, sum
    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                r_neg0[i] <= i_c[i][MW-1];
                r_mag[i]  <= i_c[i][MW-1] ? unsigned'(-i_c[i]) : unsigned'(i_c[i]);
            end
        end
        if (en[1]) begin
            r_neg1 <= r_neg0;
            for (int i = 0; i < NUM_AXES; i++) begin
                r_hh[i] <= PW'(r_mag[i][MW-1:LW]) * PW'(r_mag[i][MW-1:LW]);
                r_hl[i] <= PW'(r_mag[i][MW-1:LW]) * PW'(r_mag[i][LW-1:0]);
                r_ll[i] <= PW'(r_mag[i][LW-1:0]) * PW'(r_mag[i][LW-1:0]);
            end
        end
        if (en[2]) begin
            r_neg2 <= r_neg1;
            for (int i = 0; i < NUM_AXES; i++) begin
                r_sq2[i] <= (QW'(r_hh[i]) << (2 * LW)) + (QW'(r_hl[i]) << (LW + 1))
                          + QW'(r_ll[i]);
            end
        end
        if (en[3]) begin
            r_neg3 <= r_neg2;
            r_sq3  <= r_sq2;
            r_sum  <= SW'(r_sq2[AX_X]) + SW'(r_sq2[AX_Y]) + SW'(r_sq2[AX_Z]);
            r_zero <= (r_sq2[AX_X] | r_sq2[AX_Y] | r_sq2[AX_Z]) == '0;
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_vld[NS-1];
    assign o_neg   = r_neg3;
    assign o_sq    = r_sq3;
    assign o_sum   = r_sum;
    assign o_zero  = r_zero;
endmodule

// ----- design/tun_root.sv -----
`timescale 1ns / 1ps
`include "triangle_unit_normal_defines.svh"
module tun_root #(
    parameter int CW = 24,
    parameter int F  = 14
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [tun_pkg::NUM_AXES-1:0]       i_neg,
    input  logic [4*CW+3:0]                    i_sq [tun_pkg::NUM_AXES],
    input  logic [4*CW+5:0]                    i_sum,
    input  logic                               i_zero,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [tun_pkg::NORM_W-1:0]  o_norm [tun_pkg::NUM_AXES],
    output logic                               o_degenerate
);
    import tun_pkg::*;

    localparam int QW = 4 * CW + 4;
    localparam int SW = QW + 2;
    localparam int RW = SW + 2 * F + 3;
    localparam int YW = SW + F + 1;
    localparam int QB = F + 1;
    localparam int XW = QB + NORM_W;
    localparam int NS = F + 2;

    logic [NS-1:0] r_vld;
    logic [NS-1:0] en;

    // one restoring root digit per stage
    logic [RW-1:0]       s_r  [F+1][NUM_AXES];
    logic [YW-1:0]       s_y  [F+1][NUM_AXES];
    logic [QB-1:0]       s_q  [F+1][NUM_AXES];
    logic [SW-1:0]       s_s  [F+1];
    logic [NUM_AXES-1:0] s_ng [F+1];
    logic                s_zr [F+1];
    logic [RW-1:0]       n_d  [F+1][NUM_AXES];
    logic [NUM_AXES-1:0] n_take [F+1];

    logic [RW-1:0]       r_r  [F+1][NUM_AXES];
    logic [YW-1:0]       r_y  [F+1][NUM_AXES];
    logic [QB-1:0]       r_q  [F+1][NUM_AXES];
    logic [SW-1:0]       r_s  [F+1];
    logic [NUM_AXES-1:0] r_ng [F+1];
    logic                r_zr [F+1];

    logic [QB-1:0]              n_k   [NUM_AXES];
    logic [XW-1:0]              n_kx  [NUM_AXES];
    logic signed [NORM_W-1:0]   r_out [NUM_AXES];
    logic                       r_dg;

    always_comb begin
        en[NS-1] = !r_vld[NS-1] || i_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (en[k]) begin
                    r_vld[k] <= (k == 0) ? i_valid : r_vld[(k == 0) ? 0 : k - 1];
                end
            end
        end
    end

    always_comb begin
        for (int s = 0; s <= F; s++) begin
            if (s == 0) begin
                s_s[s]  = i_sum;
                s_ng[s] = i_neg;
                s_zr[s] = i_zero;
                for (int i = 0; i < NUM_AXES; i++) begin
                    s_r[s][i] = RW'(i_sq[i]) << (2 * F + 2);
                    s_y[s][i] = '0;
                    s_q[s][i] = '0;
                end
            end else begin
                s_s[s]  = r_s[(s == 0) ? 0 : s - 1];
                s_ng[s] = r_ng[(s == 0) ? 0 : s - 1];
                s_zr[s] = r_zr[(s == 0) ? 0 : s - 1];
                for (int i = 0; i < NUM_AXES; i++) begin
                    s_r[s][i] = r_r[(s == 0) ? 0 : s - 1][i];
                    s_y[s][i] = r_y[(s == 0) ? 0 : s - 1][i];
                    s_q[s][i] = r_q[(s == 0) ? 0 : s - 1][i];
                end
            end
            // trial: (q + 2^j)^2 s - q^2 s = (q s) << (j+1) + s << 2j
            for (int i = 0; i < NUM_AXES; i++) begin
                n_d[s][i]    = (RW'(s_y[s][i]) << (F - s + 1)) + (RW'(s_s[s]) << (2 * (F - s)));
                n_take[s][i] = n_d[s][i] <= s_r[s][i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s <= F; s++) begin
            if (en[s]) begin
                r_s[s]  <= s_s[s];
                r_ng[s] <= s_ng[s];
                r_zr[s] <= s_zr[s];
                for (int i = 0; i < NUM_AXES; i++) begin
                    r_r[s][i] <= n_take[s][i] ? s_r[s][i] - n_d[s][i] : s_r[s][i];
                    r_y[s][i] <= n_take[s][i] ? s_y[s][i] + (YW'(s_s[s]) << (F - s))
                                              : s_y[s][i];
                    r_q[s][i] <= s_q[s][i] | (QB'(n_take[s][i]) << (F - s));
                end
            end
        end
    end

    // largest odd value not above q is 2k - 1, so k = (q + 1) / 2
    always_comb begin
        for (int i = 0; i < NUM_AXES; i++) begin
            n_k[i]  = QB'(((QB + 1)'(r_q[F][i]) + (QB + 1)'(1)) >> 1);
            n_kx[i] = r_ng[F][i] ? XW'(-XW'(n_k[i])) : XW'(n_k[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[NS-1]) begin
            r_dg <= r_zr[F];
            for (int i = 0; i < NUM_AXES; i++) begin
                r_out[i] <= r_zr[F] ? '0 : signed'(n_kx[i][NORM_W-1:0]);
            end
        end
    end

    assign o_ready      = en[0];
    assign o_valid      = r_vld[NS-1];
    assign o_norm       = r_out;
    assign o_degenerate = r_dg;

    `TUN_ASSERT_IMP(a_k_bound, r_vld[F], n_k[AX_X] <= (QB'(1) << F) && n_k[AX_Y] <= (QB'(1) << F) && n_k[AX_Z] <= (QB'(1) << F), "normal magnitude above one")
    `TUN_ASSERT_IMP(a_k_nonzero, r_vld[F] && !r_zr[F], (n_k[AX_X] | n_k[AX_Y] | n_k[AX_Z]) != '0, "nondegenerate normal is all zero")
    `TUN_ASSERT_IMP(a_deg_zero, o_valid && o_degenerate, o_norm[AX_X] == '0 && o_norm[AX_Y] == '0 && o_norm[AX_Z] == '0, "degenerate beat with nonzero normal")
    `TUN_ASSERT_NEXT(a_last_move, r_vld[F] && en[NS-1], o_valid, "beat lost at output register")
endmodule

// ----- design/triangle_unit_normal.sv -----
`timescale 1ns / 1ps
// Unit face normal of one triangle. Takes p1, p2, p3 and returns the cross product of
// (p1-p2) and (p1-p3) scaled to unit length, each component rounded to nearest
// (halves away from zero) with NORMAL_FRAC_BITS fraction bits; a zero cross product
// gives o_degenerate = 1 and zero components. One triangle is accepted every cycle
// unless a stall has filled every stage; the pipeline computes the edge vectors and
// cross product, then the split squares and their sum, then the normalization,
// which resolves one result bit per stage of a restoring root recurrence and ends
// in the output register. Ready is high whenever some stage has room, so bubbles
// are squeezed out during a stall.
module triangle_unit_normal #(
    parameter int COORD_WIDTH      = 24,
    parameter int NORMAL_FRAC_BITS = 14
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [COORD_WIDTH-1:0]     i_p1_x,
    input  logic signed [COORD_WIDTH-1:0]     i_p1_y,
    input  logic signed [COORD_WIDTH-1:0]     i_p1_z,
    input  logic signed [COORD_WIDTH-1:0]     i_p2_x,
    input  logic signed [COORD_WIDTH-1:0]     i_p2_y,
    input  logic signed [COORD_WIDTH-1:0]     i_p2_z,
    input  logic signed [COORD_WIDTH-1:0]     i_p3_x,
    input  logic signed [COORD_WIDTH-1:0]     i_p3_y,
    input  logic signed [COORD_WIDTH-1:0]     i_p3_z,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [tun_pkg::NORM_W-1:0] o_norm_x,
    output logic signed [tun_pkg::NORM_W-1:0] o_norm_y,
    output logic signed [tun_pkg::NORM_W-1:0] o_norm_z,
    output logic                              o_degenerate
);
    import tun_pkg::*;

    localparam int CW = COORD_WIDTH;

    logic signed [CW-1:0]     p1 [NUM_AXES];
    logic signed [CW-1:0]     p2 [NUM_AXES];
    logic signed [CW-1:0]     p3 [NUM_AXES];
    logic signed [2*CW+1:0]   cr_c [NUM_AXES];
    logic                     cr_valid, cr_ready;
    logic [NUM_AXES-1:0]      sq_neg;
    logic [4*CW+3:0]          sq_sq [NUM_AXES];
    logic [4*CW+5:0]          sq_sum;
    logic                     sq_zero, sq_valid, sq_ready;
    logic signed [NORM_W-1:0] nm [NUM_AXES];

    assign p1[AX_X] = i_p1_x;
    assign p1[AX_Y] = i_p1_y;
    assign p1[AX_Z] = i_p1_z;
    assign p2[AX_X] = i_p2_x;
    assign p2[AX_Y] = i_p2_y;
    assign p2[AX_Z] = i_p2_z;
    assign p3[AX_X] = i_p3_x;
    assign p3[AX_Y] = i_p3_y;
    assign p3[AX_Z] = i_p3_z;

    tun_cross #(.CW(CW)) u_cross (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_p1    (p1),
        .i_p2    (p2),
        .i_p3    (p3),
        .o_valid (cr_valid),
        .i_ready (cr_ready),
        .o_c     (cr_c)
    );

    tun_square #(.CW(CW)) u_square (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (cr_valid),
        .o_ready (cr_ready),
        .i_c     (cr_c),
        .o_valid (sq_valid),
        .i_ready (sq_ready),
        .o_neg   (sq_neg),
        .o_sq    (sq_sq),
        .o_sum   (sq_sum),
        .o_zero  (sq_zero)
    );

    tun_root #(.CW(CW), .F(NORMAL_FRAC_BITS)) u_root (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (sq_valid),
        .o_ready      (sq_ready),
        .i_neg        (sq_neg),
        .i_sq         (sq_sq),
        .i_sum        (sq_sum),
        .i_zero       (sq_zero),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_norm       (nm),
        .o_degenerate (o_degenerate)
    );

    assign o_norm_x = nm[AX_X];
    assign o_norm_y = nm[AX_Y];
    assign o_norm_z = nm[AX_Z];
endmodule

// ----- tb/sv/tb_triangle_unit_normal.sv -----
`timescale 1ns / 1ps
module tb_triangle_unit_normal;
    import tun_pkg::*;

    localparam int CW   = 24;
    localparam int FRAC = 14;

    typedef logic signed [CW-1:0] t_tri [9];
    typedef struct packed {
        logic signed [NORM_W-1:0] x;
        logic signed [NORM_W-1:0] y;
        logic signed [NORM_W-1:0] z;
        logic                     deg;
    } t_normal;
    typedef struct {
        t_tri    v;
        bit      known;
        t_normal res;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_ready;
    logic o_valid;
    logic i_ready;
    logic signed [NORM_W-1:0] o_norm_x, o_norm_y, o_norm_z;
    logic o_degenerate;
    t_tri    cur_tri;
    t_normal cur_normal;
    t_normal pending_normals[$];
    int      errors = 0;
    int      hold_left = 0;
    bit      steady = 0;

    triangle_unit_normal dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_p1_x(cur_tri[0]), .i_p1_y(cur_tri[1]), .i_p1_z(cur_tri[2]),
        .i_p2_x(cur_tri[3]), .i_p2_y(cur_tri[4]), .i_p2_z(cur_tri[5]),
        .i_p3_x(cur_tri[6]), .i_p3_y(cur_tri[7]), .i_p3_z(cur_tri[8]),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_norm_x(o_norm_x), .o_norm_y(o_norm_y), .o_norm_z(o_norm_z),
        .o_degenerate(o_degenerate)
    );

    always begin
        i_clk = 1'b1; #2;
        i_clk = 1'b0; #2;
    end

    function automatic logic [NORM_W-1:0] scale_axis(longint c, logic [159:0] sum_sq);
        logic [159:0] mag, rhs, lhs, odd;
        longint lo, hi, mid;
        mag = (c < 0) ? -c : c;
        rhs = (mag * mag) << (2 * FRAC + 2);
        lo = 0;
        hi = longint'(1) << FRAC;
        while (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            odd = 2 * mid - 1;
            lhs = odd * odd * sum_sq;
            if (lhs <= rhs) lo = mid;
            else hi = mid - 1;
        end
        return (c < 0) ? NORM_W'(-lo) : NORM_W'(lo);
    endfunction

    function automatic t_normal face_normal(t_tri t);
        longint ax, ay, az, bx, by, bz, cx, cy, cz;
        logic [159:0] s, m;
        t_normal n;
        ax = longint'(t[0]) - longint'(t[3]);
        ay = longint'(t[1]) - longint'(t[4]);
        az = longint'(t[2]) - longint'(t[5]);
        bx = longint'(t[0]) - longint'(t[6]);
        by = longint'(t[1]) - longint'(t[7]);
        bz = longint'(t[2]) - longint'(t[8]);
        cx = ay * bz - by * az;
        cy = bx * az - ax * bz;
        cz = ax * by - bx * ay;
        m = (cx < 0) ? -cx : cx; s = m * m;
        m = (cy < 0) ? -cy : cy; s = s + m * m;
        m = (cz < 0) ? -cz : cz; s = s + m * m;
        if (s == 0) return '{x: '0, y: '0, z: '0, deg: 1'b1};
        n.x = scale_axis(cx, s);
        n.y = scale_axis(cy, s);
        n.z = scale_axis(cz, s);
        n.deg = 1'b0;
        return n;
    endfunction

    function automatic t_tri random_tri(int mode);
        t_tri t;
        int span;
        span = (mode == 1) ? 15 : 5000;
        for (int i = 0; i < 9; i++) begin
            if (mode == 0) t[i] = CW'($urandom);
            else t[i] = CW'($urandom_range(2 * span) - span);
        end
        if (mode == 2) begin
            for (int i = 0; i < 3; i++) t[6 + i] = 2 * t[3 + i] - t[i];
        end else if (mode == 3) begin
            for (int i = 0; i < 3; i++) t[3 + i] = t[i];
        end
        return t;
    endfunction

    task automatic send_tri(t_tri t, bit known, t_normal res);
        cur_tri = t;
        cur_normal = known ? res : face_normal(t);
        i_valid = 1'b1;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
        i_valid = 1'b0;
        while (!steady && $urandom_range(99) < 21) @(negedge i_clk);
    endtask

    // accepted input beat
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) pending_normals = {pending_normals, cur_normal};
    end

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_ready = 1'b0;
            hold_left--;
        end else begin
            i_ready = steady || ($urandom_range(99) >= 21);
        end
    end

    // output beat check
    always @(posedge i_clk) begin
        t_normal e;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_normals.size() == 0) begin
                $error("unexpected output beat");
                errors++;
            end else begin
                e = pending_normals.pop_front();
                if (o_norm_x !== e.x) begin
                    $error("norm_x exp %0d got %0d", e.x, o_norm_x); errors++;
                end
                if (o_norm_y !== e.y) begin
                    $error("norm_y exp %0d got %0d", e.y, o_norm_y); errors++;
                end
                if (o_norm_z !== e.z) begin
                    $error("norm_z exp %0d got %0d", e.z, o_norm_z); errors++;
                end
                if (o_degenerate !== e.deg) begin
                    $error("degenerate exp %0d got %0d", e.deg, o_degenerate); errors++;
                end
            end
        end
    end

    initial begin
        #4_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        t_row rows[10];
        t_normal none;
        localparam logic signed [CW-1:0] MX = {1'b0, {(CW-1){1'b1}}};
        localparam logic signed [CW-1:0] MN = {1'b1, {(CW-1){1'b0}}};
        none = '0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        for (int i = 0; i < 9; i++) cur_tri[i] = '0;
        cur_normal = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        rows[0] = '{'{0, 0, 0, 0, 0, 0, 0, 0, 0}, 1, '{0, 0, 0, 1}};
        rows[1] = '{'{0, 0, 0, -1, 0, 0, 0, -1, 0}, 1, '{0, 0, 16384, 0}};
        rows[2] = '{'{0, 0, 0, 0, -1, 0, 0, 0, -1}, 1, '{16384, 0, 0, 0}};
        rows[3] = '{'{0, 0, 0, 0, 0, -1, -1, 0, 0}, 1, '{0, 16384, 0, 0}};
        rows[4] = '{'{0, 0, 0, 0, 0, 1, 0, 1, 0}, 1, '{-16384, 0, 0, 0}};
        rows[5] = '{'{MX, MX, MX, MX, MX, MX, MX, MX, MX}, 1, '{0, 0, 0, 1}};
        rows[6] = '{'{1, 2, 3, 2, 4, 6, 3, 6, 9}, 1, '{0, 0, 0, 1}};
        rows[7] = '{'{MX, MX, MX, MN, MN, MX, MN, MX, MN}, 0, none};
        rows[8] = '{'{MN, MN, MN, MX, MN, MN, MN, MX, MX}, 0, none};
        rows[9] = '{'{MX, 0, MN, 0, MX, MN, MN, MN, 0}, 0, none};
        foreach (rows[i]) send_tri(rows[i].v, rows[i].known, rows[i].res);

        for (int n = 0; n < 2000; n++) begin
            if (n == 300) begin
                hold_left = 300;
                steady = 1;
            end
            if (n == 600) steady = 0;
            if (n == 900 || n == 1500) wait (pending_normals.size() == 0);
            case ($urandom_range(9))
                0, 1, 2, 3: send_tri(random_tri(0), 0, none);
                4, 5, 6:    send_tri(random_tri(1), 0, none);
                7:          send_tri(random_tri(4), 0, none);
                8:          send_tri(random_tri(2), 0, none);
                default:    send_tri(random_tri(3), 0, none);
            endcase
        end

        wait (pending_normals.size() == 0);
        repeat (60) @(posedge i_clk);
        if (errors == 0) $display("Test completed successfully");
        else $display("Test completed with failures");
        $finish;
    end
endmodule

// ----- triangle_unit_normal.f -----
+incdir+design
design/tun_pkg.sv
design/tun_cross.sv
design/tun_square.sv
design/tun_root.sv
design/triangle_unit_normal.sv
tb/sv/tb_triangle_unit_normal.sv
